### src/length_prefix_to_start_code_defines.svh
// assertion helpers for the asserting file length_prefix_to_start_code.sv
`ifndef LENGTH_PREFIX_TO_START_CODE_DEFINES_SVH
`define LENGTH_PREFIX_TO_START_CODE_DEFINES_SVH

// checked only outside reset
`define LPSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked on every edge, reset included
`define LPSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### src/lpsc_pkg.sv
`default_nettype none

package lpsc_pkg;

    // prefix size that rewrites the prefix in place
    localparam logic [2:0] LS_INPLACE = 3'd4;

    // input transaction payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } in_t;

    // result transaction payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       out_frame_end;
        logic       last_of_run;
    } out_t;

    // what the back end has to emit for one queued entry
    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_START = 2'd1,
        CMD_BARE  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic       valid;
        cmd_kind_t  kind;
        logic [7:0] data;
        logic       frame_end;
    } cmd_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

### src/lpsc_front.sv
`default_nettype none

module lpsc_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_wr_en,
    input  wire logic [2:0]      cfg_wr_data,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire lpsc_pkg::in_t   s_data,
    input  wire lpsc_pkg::q_stat_t q_stat,
    output lpsc_pkg::cmd_t       push_cmd
);

    typedef enum logic [2:0] {
        PH_PREFIX  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_PASS    = 3'b100
    } phase_t;

    logic [2:0]  length_size_reg;
    phase_t      phase_reg, phase_next;
    logic [1:0]  count_reg, count_next;
    logic [23:0] remain_reg, remain_next;

    logic        accept;
    logic        pass_all;
    logic [23:0] remain_dec;
    logic [23:0] remain_shift;
    logic        emit;

    assign s_ready      = !q_stat.full;
    assign accept       = s_valid && s_ready;
    assign pass_all     = (length_size_reg == 3'd0) || (length_size_reg > lpsc_pkg::LS_INPLACE);
    assign remain_dec   = remain_reg - 24'd1;
    assign remain_shift = {remain_reg[15:0], s_data.data_byte};

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_size_reg <= 3'd0;
        end else if (cfg_wr_en) begin
            length_size_reg <= cfg_wr_data;
        end
    end

    // classify the byte and work out the next parse state
    always_comb begin
        phase_next         = phase_reg;
        count_next         = count_reg;
        remain_next        = remain_reg;
        emit               = 1'b0;
        push_cmd.valid     = 1'b0;
        push_cmd.kind      = lpsc_pkg::CMD_BYTE;
        push_cmd.data      = s_data.data_byte;
        push_cmd.frame_end = s_data.frame_end;

        if (pass_all) begin
            emit = 1'b1;
        end else begin
            case (phase_reg)
                PH_PASS: begin
                    emit = 1'b1;
                end
                PH_PAYLOAD: begin
                    emit        = 1'b1;
                    remain_next = remain_dec;
                    if (remain_dec == 24'd0) begin
                        phase_next = PH_PREFIX;
                    end
                end
                PH_PREFIX: begin
                    if (length_size_reg == lpsc_pkg::LS_INPLACE) begin
                        // four byte prefix rewritten in place
                        if (count_reg == 2'd0 && s_data.data_byte != 8'd0) begin
                            emit       = 1'b1;
                            phase_next = PH_PASS;
                        end else begin
                            emit          = 1'b1;
                            remain_next   = (count_reg != 2'd0) ? remain_shift : 24'd0;
                            push_cmd.data = (count_reg == 2'd3) ? 8'd1 : 8'd0;
                            if (count_reg == 2'd3) begin
                                count_next = 2'd0;
                                phase_next = (remain_next != 24'd0) ? PH_PAYLOAD : PH_PREFIX;
                            end else begin
                                count_next = count_reg + 2'd1;
                            end
                        end
                    end else begin
                        // short prefix absorbed, start code after its last byte
                        remain_next = remain_shift;
                        if (({1'b0, count_reg} + 3'd1) >= length_size_reg) begin
                            emit          = 1'b1;
                            push_cmd.kind = lpsc_pkg::CMD_START;
                            count_next    = 2'd0;
                            phase_next    = (remain_shift != 24'd0) ? PH_PAYLOAD : PH_PREFIX;
                        end else begin
                            count_next = count_reg + 2'd1;
                        end
                    end
                end
                default: begin
                    phase_next = PH_PREFIX;
                end
            endcase
        end

        push_cmd.valid = emit;

        // frame end clears the parse state
        if (s_data.frame_end) begin
            if (!emit) begin
                push_cmd.kind = lpsc_pkg::CMD_BARE;
                push_cmd.data = 8'd0;
            end
            push_cmd.valid = 1'b1;
            phase_next     = PH_PREFIX;
            count_next     = 2'd0;
            remain_next    = 24'd0;
        end

        if (!accept) begin
            push_cmd.valid = 1'b0;
            phase_next     = phase_reg;
            count_next     = count_reg;
            remain_next    = remain_reg;
        end
    end

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_PREFIX;
            count_reg  <= 2'd0;
            remain_reg <= 24'd0;
        end else begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
        end
    end

endmodule

`default_nettype wire

### src/lpsc_queue.sv
`default_nettype none

module lpsc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lpsc_pkg::cmd_t    push_cmd,
    input  wire logic              pop,
    output lpsc_pkg::cmd_t         head_cmd,
    output lpsc_pkg::q_stat_t      q_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lpsc_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign q_stat.full  = (count_reg == FULL_CNT);
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push_cmd.valid && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_cmd     = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### src/lpsc_back.sv
`default_nettype none

module lpsc_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lpsc_pkg::cmd_t    head_cmd,
    input  wire lpsc_pkg::q_stat_t q_stat,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lpsc_pkg::out_t         m_data
);

    logic           m_valid_reg, m_valid_next;
    lpsc_pkg::out_t m_data_reg, m_data_next;
    logic [1:0]     idx_reg, idx_next;
    logic           load;
    logic           last;

    assign load    = !q_stat.empty && (!m_valid_reg || m_ready);
    assign pop     = load && last;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // expand the head entry into result bytes
    always_comb begin
        last                   = 1'b1;
        m_data_next.out_byte   = head_cmd.data;
        m_data_next.byte_valid = 1'b1;
        case (head_cmd.kind)
            lpsc_pkg::CMD_BYTE: begin
                last = 1'b1;
            end
            lpsc_pkg::CMD_START: begin
                last                 = (idx_reg == 2'd3);
                m_data_next.out_byte = (idx_reg == 2'd3) ? 8'd1 : 8'd0;
            end
            lpsc_pkg::CMD_BARE: begin
                m_data_next.out_byte   = 8'd0;
                m_data_next.byte_valid = 1'b0;
            end
            default: begin
                last = 1'b1;
            end
        endcase
        m_data_next.last_of_run   = last;
        m_data_next.out_frame_end = last && head_cmd.frame_end;
        idx_next     = load ? (last ? 2'd0 : idx_reg + 2'd1) : idx_reg;
        m_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire

### src/length_prefix_to_start_code.sv
// channel   | direction | handshake         | payload
// s_        | in        | s_valid / s_ready | lpsc_pkg::in_t  (data_byte, frame_end)
// m_        | out       | m_valid / m_ready | lpsc_pkg::out_t (out_byte, byte_valid,
//           |           |                   |   out_frame_end, last_of_run)
// cfg_      | in        | cfg_wr_en         | cfg_wr_data (length_size)
//
// one input byte per cycle while s_ready is high; results leave at one per cycle from the
// output register while m_ready is high; a start code expands to four output bytes, so
// input stalls once the command queue fills; input reaches the queue, then the output register
// reset clears parse state, queue and output valid; no clearing pass
// s_ready drops only while the command queue is full
`default_nettype none

`include "length_prefix_to_start_code_defines.svh"

module length_prefix_to_start_code #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_wr_en,
    input  wire logic [2:0]      cfg_wr_data,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire lpsc_pkg::in_t   s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output lpsc_pkg::out_t       m_data
);

    lpsc_pkg::cmd_t    push_cmd;
    lpsc_pkg::cmd_t    head_cmd;
    lpsc_pkg::q_stat_t q_stat;
    logic              pop;

    // parse and classify
    lpsc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_stat      (q_stat),
        .push_cmd    (push_cmd)
    );

    // command queue between the two halves
    lpsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    // expand into result transactions
    lpsc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // checks
    `LPSC_ASSERT(a_queue_flags, !(q_stat.full && q_stat.empty), "queue full and empty at once")
    `LPSC_ASSERT(a_end_is_last, (m_valid && m_data.out_frame_end) |-> m_data.last_of_run, "frame end not last of run")
    `LPSC_ASSERT(a_bare_is_end, (m_valid && !m_data.byte_valid) |-> m_data.out_frame_end, "bare result without frame end")
    `LPSC_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "result valid after reset")

endmodule

`default_nettype wire
